>>> design/nbfr_pkg.sv
// Shared types, constants and the CRC-8 step for the nine-bit frame receiver.
`default_nettype none

package nbfr_pkg;

    localparam int PAYLOAD_MAX_DEFAULT = 32;
    // Held length is wide enough for any payload length up to 127.
    localparam int LEN_W = 7;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_XOROUT = 8'hFF;

    localparam logic [2:0] CFG_NODE_ADDRESS = 3'd0;
    localparam logic [2:0] CFG_PROMISCUOUS_ENABLE = 3'd1;
    localparam logic [2:0] CFG_BROADCAST_ADDRESS = 3'd2;
    localparam logic [2:0] CFG_PROMISCUOUS_ADDRESS = 3'd3;
    localparam logic [2:0] CFG_CRC_POLYNOMIAL = 3'd4;

    typedef struct packed {
        logic       is_address;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  dest_addr;
        logic [7:0]  source_addr;
        logic [7:0]  frame_kind;
        logic [7:0]  sequence_number;
        logic [5:0]  payload_length;
        logic [7:0]  payload_byte;
        logic [4:0]  byte_position;
        logic        byte_valid;
        logic        last_of_frame;
        logic [31:0] good_frame_count;
        logic [31:0] bad_crc_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0] node_address;
        logic       promiscuous_enable;
        logic [7:0] broadcast_address;
        logic [7:0] promiscuous_address;
        logic [7:0] crc_polynomial;
    } cfg_t;

    // Header and counter snapshot of one good frame.
    typedef struct packed {
        logic [7:0]       dest;
        logic [7:0]       source;
        logic [7:0]       kind;
        logic [7:0]       seq;
        logic [LEN_W-1:0] length;
        logic [31:0]      good_count;
        logic [31:0]      fail_count;
    } desc_t;

    typedef struct packed {
        logic  valid;
        logic  bank;
        desc_t desc;
    } push_t;

    // One byte through an MSB-first CRC-8 with implicit x^8 term.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ poly;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/nbfr_front.sv
// Front end: word classification, header capture, CRC check and payload writes.
`default_nettype none

module nbfr_front #(
    parameter int PAYLOAD_MAX = nbfr_pkg::PAYLOAD_MAX_DEFAULT,
    parameter int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nbfr_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire nbfr_pkg::in_item_t in_data,
    input  wire logic [1:0]         bank_free,
    output logic                    wr_en,
    output logic                    wr_bank,
    output logic [IDX_W-1:0]        wr_idx,
    output logic [7:0]              wr_data,
    output nbfr_pkg::push_t         push
);

    localparam logic [7:0] LEN_LIMIT = 8'(PAYLOAD_MAX);

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_SRC     = 7'b0000010,
        PH_KIND    = 7'b0000100,
        PH_SEQ     = 7'b0001000,
        PH_LEN     = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_CRC     = 7'b1000000
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  dest_reg, dest_next;
    logic [7:0]                  source_reg, source_next;
    logic [7:0]                  kind_reg, kind_next;
    logic [7:0]                  seq_reg, seq_next;
    logic [nbfr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [nbfr_pkg::LEN_W-1:0]  fill_reg, fill_next;
    logic [nbfr_pkg::LEN_W-1:0]  fill_inc;
    logic [7:0]                  crc_reg, crc_next;
    logic [31:0]                 good_reg, good_next;
    logic [31:0]                 fail_reg, fail_next;
    logic                        bank_reg, bank_next;
    logic                        accept;
    logic                        dest_ok;
    logic [7:0]                  crc_step;
    logic [7:0]                  b;

    assign in_ready = bank_free[bank_reg];
    assign accept   = in_valid && in_ready;
    assign b        = in_data.data_byte;
    assign fill_inc = fill_reg + nbfr_pkg::LEN_W'(1);

    assign dest_ok = cfg.promiscuous_enable
                     || (cfg.node_address == cfg.promiscuous_address)
                     || (b == cfg.node_address)
                     || (b == cfg.broadcast_address);

    // Address word restarts the CRC from its initial value.
    assign crc_step = nbfr_pkg::crc8_byte(in_data.is_address ? nbfr_pkg::CRC_INIT : crc_reg,
                                          b, cfg.crc_polynomial);

    always_comb
    begin
        phase_next  = phase_reg;
        dest_next   = dest_reg;
        source_next = source_reg;
        kind_next   = kind_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        fill_next   = fill_reg;
        crc_next    = crc_reg;
        good_next   = good_reg;
        fail_next   = fail_reg;
        bank_next   = bank_reg;
        wr_en       = 1'b0;
        wr_bank     = bank_reg;
        wr_idx      = fill_reg[IDX_W-1:0];
        wr_data     = b;
        push.valid  = 1'b0;
        push.bank   = bank_reg;
        push.desc.dest       = dest_reg;
        push.desc.source     = source_reg;
        push.desc.kind       = kind_reg;
        push.desc.seq        = seq_reg;
        push.desc.length     = len_reg;
        push.desc.good_count = good_reg + 32'd1;
        push.desc.fail_count = fail_reg;

        if (accept)
        begin
            if (in_data.is_address)
            begin
                if (dest_ok)
                begin
                    dest_next  = b;
                    crc_next   = crc_step;
                    phase_next = PH_SRC;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_SRC:
                    begin
                        source_next = b;
                        crc_next    = crc_step;
                        phase_next  = PH_KIND;
                    end
                    PH_KIND:
                    begin
                        kind_next  = b;
                        crc_next   = crc_step;
                        phase_next = PH_SEQ;
                    end
                    PH_SEQ:
                    begin
                        seq_next   = b;
                        crc_next   = crc_step;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (b > LEN_LIMIT)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            len_next   = b[nbfr_pkg::LEN_W-1:0];
                            fill_next  = '0;
                            crc_next   = crc_step;
                            phase_next = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        wr_en     = 1'b1;
                        crc_next  = crc_step;
                        fill_next = fill_inc;
                        if (fill_inc >= len_reg)
                            phase_next = PH_CRC;
                    end
                    PH_CRC:
                    begin
                        phase_next = PH_IDLE;
                        if ((crc_reg ^ nbfr_pkg::CRC_XOROUT) != b)
                        begin
                            fail_next = fail_reg + 32'd1;
                        end
                        else
                        begin
                            good_next  = good_reg + 32'd1;
                            push.valid = 1'b1;
                            bank_next  = ~bank_reg;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            dest_reg   <= '0;
            source_reg <= '0;
            kind_reg   <= '0;
            seq_reg    <= '0;
            len_reg    <= '0;
            fill_reg   <= '0;
            crc_reg    <= nbfr_pkg::CRC_INIT;
            good_reg   <= '0;
            fail_reg   <= '0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            dest_reg   <= dest_next;
            source_reg <= source_next;
            kind_reg   <= kind_next;
            seq_reg    <= seq_next;
            len_reg    <= len_next;
            fill_reg   <= fill_next;
            crc_reg    <= crc_next;
            good_reg   <= good_next;
            fail_reg   <= fail_next;
            bank_reg   <= bank_next;
        end
    end

    // A payload byte always lands below the declared length.
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> fill_reg < len_reg)
        else $error("payload write beyond frame length");

    // A pushed frame always flips the write bank.
    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |=> bank_reg != $past(bank_reg))
        else $error("write bank did not advance after frame push");

    // Frame is pushed only from the CRC phase.
    a_push_phase: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> phase_reg == PH_CRC)
        else $error("frame pushed outside CRC phase");

endmodule

`default_nettype wire

>>> design/nbfr_back.sv
// Back end: two-bank payload memory, frame queue and result stream with output register.
`default_nettype none

module nbfr_back #(
    parameter int PAYLOAD_MAX = nbfr_pkg::PAYLOAD_MAX_DEFAULT,
    parameter int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic                wr_bank,
    input  wire logic [IDX_W-1:0]    wr_idx,
    input  wire logic [7:0]          wr_data,
    input  wire nbfr_pkg::push_t     push,
    output logic [1:0]               bank_free,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output nbfr_pkg::out_item_t      out_data
);

    localparam int MEM_DEPTH = 2 * (2 ** IDX_W);

    logic [7:0]                 mem [MEM_DEPTH];
    logic [7:0]                 rd_data_reg;

    nbfr_pkg::desc_t            desc_reg [2];
    logic [1:0]                 busy_reg, busy_next;
    logic                       rd_bank_reg, rd_bank_next;
    logic [nbfr_pkg::LEN_W-1:0] k_reg, k_next;
    logic [nbfr_pkg::LEN_W-1:0] k_inc;

    logic                       s1_valid_reg, s1_valid_next;
    nbfr_pkg::desc_t            s1_desc_reg;
    logic [4:0]                 s1_pos_reg;
    logic                       s1_byte_valid_reg;
    logic                       s1_last_reg;

    logic                       out_valid_reg, out_valid_next;
    nbfr_pkg::out_item_t        out_data_reg;

    nbfr_pkg::desc_t            head;
    logic                       head_valid;
    logic                       issue;
    logic                       issue_last;
    logic                       out_load;
    logic                       s1_free;

    assign head       = desc_reg[rd_bank_reg];
    assign head_valid = busy_reg[rd_bank_reg];
    assign k_inc      = k_reg + nbfr_pkg::LEN_W'(1);
    // An empty payload still yields one result, so k+1 >= 0 ends it at once.
    assign issue_last = (k_inc >= head.length);

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free  = !s1_valid_reg || out_load;
    assign issue    = head_valid && s1_free;

    assign bank_free = ~busy_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Payload memory: front writes one bank while this side reads the other.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[{wr_bank, wr_idx}] <= wr_data;
        if (issue)
            rd_data_reg <= mem[{rd_bank_reg, k_reg[IDX_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            desc_reg[push.bank] <= push.desc;
    end

    always_comb
    begin
        busy_next    = busy_reg;
        rd_bank_next = rd_bank_reg;
        k_next       = k_reg;
        if (push.valid)
            busy_next[push.bank] = 1'b1;
        if (issue)
        begin
            if (issue_last)
            begin
                // Read data is already captured, so the bank can be refilled.
                busy_next[rd_bank_reg] = 1'b0;
                rd_bank_next           = ~rd_bank_reg;
                k_next                 = '0;
            end
            else
            begin
                k_next = k_inc;
            end
        end
    end

    assign s1_valid_next  = issue ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_desc_reg       <= head;
            s1_pos_reg        <= 5'(k_reg);
            s1_byte_valid_reg <= (head.length != '0);
            s1_last_reg       <= issue_last;
        end
        if (out_load)
        begin
            out_data_reg.dest_addr        <= s1_desc_reg.dest;
            out_data_reg.source_addr      <= s1_desc_reg.source;
            out_data_reg.frame_kind       <= s1_desc_reg.kind;
            out_data_reg.sequence_number  <= s1_desc_reg.seq;
            out_data_reg.payload_length   <= 6'(s1_desc_reg.length);
            out_data_reg.payload_byte     <= s1_byte_valid_reg ? rd_data_reg : 8'd0;
            out_data_reg.byte_position    <= s1_pos_reg;
            out_data_reg.byte_valid       <= s1_byte_valid_reg;
            out_data_reg.last_of_frame    <= s1_last_reg;
            out_data_reg.good_frame_count <= s1_desc_reg.good_count;
            out_data_reg.bad_crc_count    <= s1_desc_reg.fail_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 2'b00;
            rd_bank_reg   <= 1'b0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rd_bank_reg   <= rd_bank_next;
            k_reg         <= k_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_push_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !busy_reg[push.bank])
        else $error("frame pushed into a bank still in use");

    a_release_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && issue_last) |=> !busy_reg[$past(rd_bank_reg)])
        else $error("bank not released after last read");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> (s1_valid_reg && $stable(rd_data_reg)))
        else $error("read stage lost data while stalled");

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> k_reg == '0)
        else $error("byte index not cleared between frames");

endmodule

`default_nettype wire

>>> design/nine_bit_frame_receiver.sv
// Top level of the nine-bit multidrop frame receiver with CRC-8 check.
// Takes one 9-bit bus word per cycle while in_ready is high. Address words filter on
// node, broadcast and promiscuous settings; the front end collects the header, writes
// the payload into one of two memory banks and checks the CRC-8 (init 0xFF, final xor
// 0xFF) byte by byte as words arrive. A good frame is handed to the back end, which
// streams one result per cycle while out_ready is high (one per payload byte, or a
// single result for an empty payload) through a read stage and an output register.
// Input is stalled only while both payload banks hold frames not yet fully read from
// memory. A frame of n payload bytes is n + 6 input words and gives max(n, 1) results.
// The payload memory needs no clearing after reset. Register writes are registered.
`default_nettype none

module nine_bit_frame_receiver #(
    parameter int PAYLOAD_MAX = nbfr_pkg::PAYLOAD_MAX_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire nbfr_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output nbfr_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [7:0]          cfg_wdata
);

    localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    nbfr_pkg::cfg_t  cfg_reg;
    logic [1:0]      bank_free;
    logic            wr_en;
    logic            wr_bank;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]      wr_data;
    nbfr_pkg::push_t push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_address        <= 8'd1;
            cfg_reg.promiscuous_enable  <= 1'b0;
            cfg_reg.broadcast_address   <= 8'hFF;
            cfg_reg.promiscuous_address <= 8'd0;
            cfg_reg.crc_polynomial      <= 8'h07;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nbfr_pkg::CFG_NODE_ADDRESS:        cfg_reg.node_address <= cfg_wdata;
                nbfr_pkg::CFG_PROMISCUOUS_ENABLE:  cfg_reg.promiscuous_enable <= cfg_wdata[0];
                nbfr_pkg::CFG_BROADCAST_ADDRESS:   cfg_reg.broadcast_address <= cfg_wdata;
                nbfr_pkg::CFG_PROMISCUOUS_ADDRESS: cfg_reg.promiscuous_address <= cfg_wdata;
                nbfr_pkg::CFG_CRC_POLYNOMIAL:      cfg_reg.crc_polynomial <= cfg_wdata;
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    nbfr_front #(
        .PAYLOAD_MAX(PAYLOAD_MAX),
        .IDX_W      (IDX_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .bank_free(bank_free),
        .wr_en    (wr_en),
        .wr_bank  (wr_bank),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .push     (push)
    );

    nbfr_back #(
        .PAYLOAD_MAX(PAYLOAD_MAX),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_bank  (wr_bank),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .push     (push),
        .bank_free(bank_free),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

>>> sim/tb_nine_bit_frame_receiver.sv
// Self-checking testbench for the nine-bit frame receiver: framed bus traffic against a predictor.
module tb_nine_bit_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import nbfr_pkg::*;

    localparam int FRAME_MAX = PAYLOAD_MAX_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int PHASE_WORDS = 40;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_SOURCE,
        RX_KIND,
        RX_SEQUENCE,
        RX_LENGTH,
        RX_PAYLOAD,
        RX_CHECK
    } rx_phase_t;

    typedef enum int {
        PACE_NONE,
        PACE_RANDOM,
        PACE_RARE
    } pace_t;

    typedef struct {
        in_item_t    word;
        int unsigned gap;
    } bus_slot_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;

    // predictor state
    cfg_t        live_cfg;
    rx_phase_t   rx_phase;
    logic [7:0]  hdr_dest;
    logic [7:0]  hdr_source;
    logic [7:0]  hdr_kind;
    logic [7:0]  hdr_sequence;
    logic [7:0]  hdr_length;
    int          fill_pos;
    logic [7:0]  crc_acc;
    logic [7:0]  payload_mem [FRAME_MAX];
    logic [31:0] good_tally;
    logic [31:0] bad_tally;
    out_item_t   awaited [$];

    bus_slot_t   outbound [$];
    logic [7:0]  build_crc;
    pace_t       send_pace = PACE_RANDOM;
    pace_t       recv_pace = PACE_RANDOM;
    int unsigned gap_count = 0;
    int unsigned recv_hold = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    nine_bit_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // bitwise MSB-first form, polynomial taken live
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       top;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            top = r[7] ^ b[i];
            r = {r[6:0], 1'b0} ^ (top ? live_cfg.crc_polynomial : 8'h00);
        end
        return r;
    endfunction

    function automatic logic dest_taken(input logic [7:0] d);
        return live_cfg.promiscuous_enable
            || live_cfg.node_address == live_cfg.promiscuous_address
            || d == live_cfg.node_address
            || d == live_cfg.broadcast_address;
    endfunction

    function automatic void absorb_word(input in_item_t w);
        out_item_t r;
        int        n;
        if (w.is_address)
        begin
            if (dest_taken(w.data_byte))
            begin
                hdr_dest = w.data_byte;
                crc_acc = crc_step(CRC_INIT, w.data_byte);
                rx_phase = RX_SOURCE;
            end
            else
                rx_phase = RX_IDLE;
            return;
        end
        case (rx_phase)
            RX_SOURCE:
            begin
                hdr_source = w.data_byte;
                crc_acc = crc_step(crc_acc, w.data_byte);
                rx_phase = RX_KIND;
            end
            RX_KIND:
            begin
                hdr_kind = w.data_byte;
                crc_acc = crc_step(crc_acc, w.data_byte);
                rx_phase = RX_SEQUENCE;
            end
            RX_SEQUENCE:
            begin
                hdr_sequence = w.data_byte;
                crc_acc = crc_step(crc_acc, w.data_byte);
                rx_phase = RX_LENGTH;
            end
            RX_LENGTH:
            begin
                if (w.data_byte > FRAME_MAX)
                    rx_phase = RX_IDLE;
                else
                begin
                    hdr_length = w.data_byte;
                    fill_pos = 0;
                    crc_acc = crc_step(crc_acc, w.data_byte);
                    rx_phase = (w.data_byte == 8'd0) ? RX_CHECK : RX_PAYLOAD;
                end
            end
            RX_PAYLOAD:
            begin
                payload_mem[fill_pos] = w.data_byte;
                crc_acc = crc_step(crc_acc, w.data_byte);
                fill_pos++;
                if (fill_pos >= hdr_length)
                    rx_phase = RX_CHECK;
            end
            RX_CHECK:
            begin
                rx_phase = RX_IDLE;
                if ((crc_acc ^ CRC_XOROUT) != w.data_byte)
                    bad_tally++;
                else
                begin
                    good_tally++;
                    n = hdr_length;
                    // an empty payload still yields one result
                    for (int k = 0; k < ((n == 0) ? 1 : n); k++)
                    begin
                        r.dest_addr = hdr_dest;
                        r.source_addr = hdr_source;
                        r.frame_kind = hdr_kind;
                        r.sequence_number = hdr_sequence;
                        r.payload_length = hdr_length[5:0];
                        r.payload_byte = (n == 0) ? 8'h00 : payload_mem[k];
                        r.byte_position = 5'(k);
                        r.byte_valid = (n != 0);
                        r.last_of_frame = (k + 1 >= n);
                        r.good_frame_count = good_tally;
                        r.bad_crc_count = bad_tally;
                        awaited.push_back(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_result(input out_item_t got);
        out_item_t want;
        string     bad;
        if (awaited.size() == 0)
        begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("unexpected result: %p", got);
            return;
        end
        want = awaited.pop_front();
        bad = "";
        if (got.dest_addr !== want.dest_addr) bad = {bad, " dest_addr"};
        if (got.source_addr !== want.source_addr) bad = {bad, " source_addr"};
        if (got.frame_kind !== want.frame_kind) bad = {bad, " frame_kind"};
        if (got.sequence_number !== want.sequence_number) bad = {bad, " sequence_number"};
        if (got.payload_length !== want.payload_length) bad = {bad, " payload_length"};
        if (got.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
        if (got.byte_position !== want.byte_position) bad = {bad, " byte_position"};
        if (got.byte_valid !== want.byte_valid) bad = {bad, " byte_valid"};
        if (got.last_of_frame !== want.last_of_frame) bad = {bad, " last_of_frame"};
        if (got.good_frame_count !== want.good_frame_count) bad = {bad, " good_frame_count"};
        if (got.bad_crc_count !== want.bad_crc_count) bad = {bad, " bad_crc_count"};
        if (bad != "")
        begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("mismatch in%s: expected %p, got %p", bad, want, got);
        end
    endfunction

    function automatic int unsigned draw_wait(input pace_t p);
        case (p)
            PACE_NONE:   return 0;
            PACE_RANDOM: return $urandom_range(0, 15);
            default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb_word(in_data);
            if (!in_valid || in_ready)
            begin
                if (outbound.size() == 0)
                    in_valid <= 1'b0;
                else if (gap_count < outbound[0].gap)
                begin
                    gap_count++;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data <= outbound[0].word;
                    in_valid <= 1'b1;
                    void'(outbound.pop_front());
                    gap_count = 0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_result(out_data);
                recv_hold = draw_wait(recv_pace);
            end
            else if (!out_valid && recv_hold == 0 && $urandom_range(0, 15) == 0)
                recv_hold = draw_wait(recv_pace);
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_word(input logic is_addr, input logic [7:0] b);
        bus_slot_t s;
        s.word.is_address = is_addr;
        s.word.data_byte = b;
        s.gap = draw_wait(send_pace);
        outbound.push_back(s);
    endtask

    task automatic open_frame(input logic [7:0] dest);
        send_word(1'b1, dest);
        build_crc = crc_step(CRC_INIT, dest);
    endtask

    task automatic frame_byte(input logic [7:0] b);
        send_word(1'b0, b);
        build_crc = crc_step(build_crc, b);
    endtask

    task automatic close_frame(input logic intact);
        logic [7:0] spoil;
        spoil = intact ? 8'h00 : 8'($urandom_range(1, 255));
        send_word(1'b0, build_crc ^ CRC_XOROUT ^ spoil);
    endtask

    task automatic send_frame(input logic [7:0] dest, input int len, input logic intact);
        open_frame(dest);
        repeat (3) frame_byte(8'($urandom));
        frame_byte(8'(len));
        repeat (len) frame_byte(8'($urandom));
        close_frame(intact);
    endtask

    function automatic logic [7:0] pick_dest();
        int unsigned c;
        c = $urandom_range(0, 9);
        if (c < 4)
            return live_cfg.node_address;
        else if (c < 6)
            return live_cfg.broadcast_address;
        return 8'($urandom);
    endfunction

    function automatic int pick_length();
        int unsigned c;
        c = $urandom_range(0, 19);
        if (c < 13)
            return $urandom_range(0, 6);
        else if (c < 18)
            return $urandom_range(7, FRAME_MAX - 1);
        return FRAME_MAX;
    endfunction

    task automatic random_traffic(input int budget);
        int          used;
        int unsigned pick;
        int          len;
        int          cut;
        used = 0;
        while (used < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = pick_length();
                send_frame(pick_dest(), len, $urandom_range(0, 6) != 0);
                used += len + 6;
            end
            else if (pick < 78)
            begin
                // oversize length, tail words fall on an idle receiver
                open_frame(pick_dest());
                repeat (3) frame_byte(8'($urandom));
                frame_byte(8'($urandom_range(FRAME_MAX + 1, 255)));
                repeat ($urandom_range(0, 3)) send_word(1'b0, 8'($urandom));
                used += 5;
            end
            else if (pick < 88)
            begin
                // partial frame, then a fresh address word restarts reception
                len = $urandom_range(1, 8);
                cut = $urandom_range(1, len + 3);
                open_frame(pick_dest());
                for (int i = 0; i < cut; i++)
                    frame_byte((i == 3) ? 8'(len) : 8'($urandom));
                len = pick_length();
                send_frame(pick_dest(), len, 1'b1);
                used += cut + len + 7;
            end
            else if (pick < 95)
            begin
                send_word(1'b1, 8'($urandom));
                repeat ($urandom_range(1, 5)) send_word(1'b0, 8'($urandom));
                used += 1;
            end
            else
                repeat ($urandom_range(1, 3)) send_word(1'b0, 8'($urandom));
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_NODE_ADDRESS:        live_cfg.node_address = val;
            CFG_PROMISCUOUS_ENABLE:  live_cfg.promiscuous_enable = val[0];
            CFG_BROADCAST_ADDRESS:   live_cfg.broadcast_address = val;
            CFG_PROMISCUOUS_ADDRESS: live_cfg.promiscuous_address = val;
            CFG_CRC_POLYNOMIAL:      live_cfg.crc_polynomial = val;
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic setup_filter(input logic [7:0] node, input logic [7:0] prom_en,
                                input logic [7:0] bcast, input logic [7:0] prom_addr,
                                input logic [7:0] poly);
        write_reg(CFG_NODE_ADDRESS, node);
        write_reg(CFG_PROMISCUOUS_ENABLE, prom_en);
        write_reg(CFG_BROADCAST_ADDRESS, bcast);
        write_reg(CFG_PROMISCUOUS_ADDRESS, prom_addr);
        write_reg(CFG_CRC_POLYNOMIAL, poly);
    endtask

    // wait out every pending request and result, plus pipeline slack
    task automatic drain();
        while (outbound.size() != 0 || in_valid || awaited.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        live_cfg = '{node_address: 8'd1, promiscuous_enable: 1'b0, broadcast_address: 8'hFF,
                     promiscuous_address: 8'd0, crc_polynomial: 8'd7};
        rx_phase = RX_IDLE;
        hdr_dest = '0;
        hdr_source = '0;
        hdr_kind = '0;
        hdr_sequence = '0;
        hdr_length = '0;
        fill_pos = 0;
        crc_acc = CRC_INIT;
        good_tally = '0;
        bad_tally = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // data word on an idle bus
        send_word(1'b0, 8'h00);
        // empty payload for this node
        open_frame(live_cfg.node_address);
        frame_byte(8'h00);
        frame_byte(8'hFF);
        frame_byte(8'h00);
        frame_byte(8'h00);
        close_frame(1'b1);
        // broadcast with a bad check byte
        open_frame(8'hFF);
        frame_byte(8'hFF);
        frame_byte(8'h00);
        frame_byte(8'hFF);
        frame_byte(8'd1);
        frame_byte(8'hFF);
        close_frame(1'b0);
        // someone else's frame
        send_word(1'b1, 8'h55);
        send_word(1'b0, 8'hAA);
        // length over the limit
        open_frame(live_cfg.node_address);
        repeat (3) frame_byte(8'h11);
        frame_byte(8'(FRAME_MAX + 1));
        // address word in the middle of a frame
        open_frame(live_cfg.node_address);
        frame_byte(8'h22);
        open_frame(8'hFF);
        frame_byte(8'h33);
        frame_byte(8'h44);
        // polynomial change in the middle of a frame
        drain();
        write_reg(CFG_CRC_POLYNOMIAL, 8'h31);
        frame_byte(8'h55);
        frame_byte(8'd1);
        frame_byte(8'h66);
        close_frame(1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    setup_filter(8'($urandom), 8'h00, 8'($urandom), 8'($urandom), 8'($urandom));
                    // slots past the register list must be ignored
                    for (int i = CFG_CRC_POLYNOMIAL + 1; i < 8; i++)
                        write_reg(3'(i), 8'($urandom));
                    send_pace = PACE_RANDOM;
                    recv_pace = PACE_RANDOM;
                    send_frame(live_cfg.node_address, FRAME_MAX, 1'b1);
                end
                1:
                begin
                    setup_filter(8'($urandom), 8'hFF, 8'($urandom), 8'($urandom), 8'hFF);
                    send_pace = PACE_NONE;
                    recv_pace = PACE_NONE;
                end
                2:
                begin
                    // promiscuous through node address matching the promiscuous address
                    setup_filter(8'h00, 8'hFE, 8'h00, 8'h00, 8'h00);
                    send_pace = PACE_RANDOM;
                    recv_pace = PACE_NONE;
                end
                3:
                begin
                    setup_filter(8'hFF, 8'h00, 8'h00, 8'hFE, 8'h1D);
                    send_pace = PACE_NONE;
                    recv_pace = PACE_RANDOM;
                end
                default:
                begin
                    setup_filter(8'($urandom), 8'($urandom_range(0, 3) == 0), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                    send_pace = (ph == 4) ? PACE_RARE : PACE_RANDOM;
                    recv_pace = PACE_RARE;
                end
            endcase
            random_traffic(PHASE_WORDS);
            drain();
        end

        if (mismatches == 0 && awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
